FILE: sv/swk_pkg.sv
// ----------------------------------------------------------------------------
// swk_pkg
// shared constants and the cordic arctangent table for the swerve kinematics
// ----------------------------------------------------------------------------
package swk_pkg;

    localparam int FRAC_BITS_DEF     = 14;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int GUARD             = 8;   // extra fraction bits inside
    localparam int RATIO_SHIFT       = 6;   // 14 ratio bits minus guard bits
    localparam int DW                = 30;  // internal datapath width
    localparam int LW                = 27;  // wheel length width
    localparam int TABLE_LEN         = 24;

    localparam logic signed [30:0] KINV        = 31'sd652032874;
    localparam logic [14:0]        RATIO_RESET = 15'd11585;
    localparam logic [31:0]        HALF_TURN   = 32'h8000_0000;

    // arctangent of 2^-i, 2^32 steps per turn
    function automatic logic signed [31:0] atan_val(input int idx);
        logic signed [31:0] v;
        case (idx)
            0:       v = 32'sd536870912;
            1:       v = 32'sd316933405;
            2:       v = 32'sd167458907;
            3:       v = 32'sd85004756;
            4:       v = 32'sd42667331;
            5:       v = 32'sd21354465;
            6:       v = 32'sd10679838;
            7:       v = 32'sd5340245;
            8:       v = 32'sd2670163;
            9:       v = 32'sd1335087;
            10:      v = 32'sd667544;
            11:      v = 32'sd333772;
            12:      v = 32'sd166886;
            13:      v = 32'sd83443;
            14:      v = 32'sd41721;
            15:      v = 32'sd20860;
            16:      v = 32'sd10430;
            17:      v = 32'sd5215;
            18:      v = 32'sd2607;
            19:      v = 32'sd1303;
            20:      v = 32'sd651;
            21:      v = 32'sd325;
            22:      v = 32'sd162;
            23:      v = 32'sd81;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/swerve_wheel_kinematics_top.sv
// ----------------------------------------------------------------------------
// swerve_wheel_kinematics_top
// fixed point swerve drive inverse kinematics, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   slave stream takes one drive request per beat: x, y, spin (q1.14) and
//   the gimbal yaw as a binary angle. master stream returns four wheel
//   speeds (q1.14, normalized when any exceeds 1.0) and four steer angles.
//   the ratio register is written through i_cfg_we / i_cfg_wdata; write it
//   only while no request is in flight (the block does not enforce this).
// stages, in order: input stage, rotation cordic, gain multiply, wheel sums,
//   vector setup, four vectoring cordics, gain multiply, max search,
//   restoring divider (one quotient bit per stage), output register.
// throughput: one request per cycle unless the output stalls; every stage is
//   a register slice and the divider is unrolled per lane.
// stall: when the output register holds a result that is not taken the
//   whole pipeline freezes (single clock enable), so nothing is lost.
// reset: synchronous active low, clears all valid bits and loads the ratio
//   register with its default; payload registers are not reset.
// ----------------------------------------------------------------------------
module swerve_wheel_kinematics_top #(
    parameter int FRAC_BITS     = swk_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = swk_pkg::CORDIC_STAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [14:0]  i_cfg_wdata,     // drivebase_ratio
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // drive_x, drive_y, spin_cmd, gimbal_angle (16 bits each, low first)
    input  logic [63:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // speed fr, fl, bl, br (15 bits each), angle fr, fl, bl, br (16 each),
    // 4 zero bits on top
    output logic [127:0] o_m_axis_tdata
);
    import swk_pkg::*;

    localparam int N = CORDIC_STAGES;
    localparam int D = FRAC_BITS + 1;      // quotient bits
    localparam logic [31:0] ONE_VAL = 32'd1 << (FRAC_BITS + GUARD);
    localparam logic signed [31:0] QTR_POS = 32'sh4000_0000;
    localparam logic signed [31:0] QTR_NEG = -32'sh4000_0000;

    // global pipeline advance
    logic ce;
    logic r_ov;
    logic [127:0] r_odata;
    assign ce = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = ce;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;

    // ratio register
    logic [14:0] r_ratio;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_RESET;
        end else if (i_cfg_we) begin
            r_ratio <= i_cfg_wdata;
        end
    end

    // ---------------- input stage: scale, quadrant fold, spin term --------
    logic signed [15:0] in_x, in_y, in_s;
    logic [15:0]        in_g;
    logic signed [31:0] in_z;
    logic               in_flip;
    logic signed [DW-1:0] in_bx, in_by;
    logic signed [31:0] in_kp;

    assign in_x = i_s_axis_tdata[15:0];
    assign in_y = i_s_axis_tdata[31:16];
    assign in_s = i_s_axis_tdata[47:32];
    assign in_g = i_s_axis_tdata[63:48];
    assign in_z = {in_g, 16'h0000};
    assign in_flip = (in_z > QTR_POS) || (in_z < QTR_NEG);
    assign in_bx = DW'($signed({in_x, 8'h00}));
    assign in_by = DW'($signed({in_y, 8'h00}));
    assign in_kp = 32'(in_s) * 32'($signed({1'b0, r_ratio}));

    logic signed [DW-1:0] r_rx [0:N];
    logic signed [DW-1:0] r_ry [0:N];
    logic signed [31:0]   r_rz [0:N];
    logic signed [DW-1:0] r_rk [0:N];
    logic                 r_rv [0:N];

    // translation is negated, then negated back when the angle is folded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv[0] <= 1'b0;
        end else if (ce) begin
            r_rv[0] <= i_s_axis_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_rx[0] <= in_flip ? in_bx : -in_bx;
            r_ry[0] <= in_flip ? in_by : -in_by;
            r_rz[0] <= in_flip ? (in_z ^ HALF_TURN) : in_z;
            r_rk[0] <= DW'(in_kp >>> RATIO_SHIFT);
        end
    end

    // ---------------- rotation cordic ----------------
    for (genvar i = 0; i < N; i++) begin : g_rot
        logic signed [DW-1:0] dx, dy;
        assign dx = r_ry[i] >>> i;
        assign dy = r_rx[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rv[i+1] <= 1'b0;
            end else if (ce) begin
                r_rv[i+1] <= r_rv[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_rk[i+1] <= r_rk[i];
                if (!r_rz[i][31]) begin
                    r_rx[i+1] <= r_rx[i] - dx;
                    r_ry[i+1] <= r_ry[i] + dy;
                    r_rz[i+1] <= r_rz[i] - atan_val(i);
                end else begin
                    r_rx[i+1] <= r_rx[i] + dx;
                    r_ry[i+1] <= r_ry[i] - dy;
                    r_rz[i+1] <= r_rz[i] + atan_val(i);
                end
            end
        end
    end

    // ---------------- rotation gain correction ----------------
    logic signed [DW+30:0] kx_p, ky_p;
    logic signed [DW-1:0]  r_kx, r_ky, r_kk;
    logic                  r_kv;
    assign kx_p = (DW+31)'(r_rx[N]) * (DW+31)'(KINV);
    assign ky_p = (DW+31)'(r_ry[N]) * (DW+31)'(KINV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kv <= 1'b0;
        end else if (ce) begin
            r_kv <= r_rv[N];
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_kx <= kx_p[DW+29:30];
            r_ky <= ky_p[DW+29:30];
            r_kk <= r_rk[N];
        end
    end

    // ---------------- wheel sums ----------------
    logic signed [DW-1:0] r_a, r_b, r_c, r_d;
    logic                 r_av;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (ce) begin
            r_av <= r_kv;
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a <= r_kx - r_kk;
            r_b <= r_kx + r_kk;
            r_c <= r_ky - r_kk;
            r_d <= r_ky + r_kk;
        end
    end

    // ---------------- vectoring cordics, lanes fr, fl, bl, br ----------------
    logic signed [DW-1:0] r_vx   [0:3][0:N];
    logic signed [DW-1:0] r_vy   [0:3][0:N];
    logic signed [31:0]   r_vz   [0:3][0:N];
    logic                 r_vzero[0:3][0:N];
    logic                 r_vv   [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vv[0] <= 1'b0;
        end else if (ce) begin
            r_vv[0] <= r_av;
        end
    end
    for (genvar i = 0; i < N; i++) begin : g_vvalid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vv[i+1] <= 1'b0;
            end else if (ce) begin
                r_vv[i+1] <= r_vv[i];
            end
        end
    end

    // lane vectors: fr (b,d), fl (b,c), bl (a,c), br (a,d)
    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic signed [DW-1:0] vp, vq;
        assign vp = (l == 0 || l == 1) ? r_b : r_a;
        assign vq = (l == 0 || l == 3) ? r_d : r_c;

        // left half plane is mirrored and starts at half a turn
        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_vzero[l][0] <= (vp == '0) && (vq == '0);
                if (vq < 0) begin
                    r_vx[l][0] <= -vq;
                    r_vy[l][0] <= -vp;
                    r_vz[l][0] <= HALF_TURN;
                end else begin
                    r_vx[l][0] <= vq;
                    r_vy[l][0] <= vp;
                    r_vz[l][0] <= '0;
                end
            end
        end

        for (genvar i = 0; i < N; i++) begin : g_vec
            logic signed [DW-1:0] dx, dy;
            assign dx = r_vy[l][i] >>> i;
            assign dy = r_vx[l][i] >>> i;
            always_ff @(posedge i_clk) begin
                if (ce) begin
                    r_vzero[l][i+1] <= r_vzero[l][i];
                    if (!r_vy[l][i][DW-1]) begin
                        r_vx[l][i+1] <= r_vx[l][i] + dx;
                        r_vy[l][i+1] <= r_vy[l][i] - dy;
                        r_vz[l][i+1] <= r_vz[l][i] + atan_val(i);
                    end else begin
                        r_vx[l][i+1] <= r_vx[l][i] - dx;
                        r_vy[l][i+1] <= r_vy[l][i] + dy;
                        r_vz[l][i+1] <= r_vz[l][i] - atan_val(i);
                    end
                end
            end
        end
    end

    // ---------------- length gain correction, angle rounding ----------------
    logic [LW-1:0] r_len [0:3];
    logic [15:0]   r_ang [0:3];
    logic          r_lv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv <= 1'b0;
        end else if (ce) begin
            r_lv <= r_vv[N];
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_len
        logic signed [DW+30:0] lp;
        logic signed [DW-1:0]  lx;
        logic [31:0]           az;
        assign lp = (DW+31)'(r_vx[l][N]) * (DW+31)'(KINV);
        assign lx = lp[DW+29:30];
        assign az = r_vz[l][N] + 32'h0000_8000;
        always_ff @(posedge i_clk) begin
            if (ce) begin
                if (r_vzero[l][N] || lx < 0) begin
                    r_len[l] <= '0;
                end else begin
                    r_len[l] <= lx[LW-1:0];
                end
                r_ang[l] <= r_vzero[l][N] ? 16'h0000 : az[31:16];
            end
        end
    end

    // ---------------- max search and divider ----------------
    logic [LW-1:0] mx01, mx23, mx_all;
    assign mx01   = (r_len[1] > r_len[0]) ? r_len[1] : r_len[0];
    assign mx23   = (r_len[3] > r_len[2]) ? r_len[3] : r_len[2];
    assign mx_all = (mx23 > mx01) ? mx23 : mx01;

    logic [LW-1:0] r_dm   [0:D];
    logic          r_dbig [0:D];
    logic          r_dv   [0:D];
    logic [LW:0]   r_dr   [0:3][0:D];
    logic [D-1:0]  r_dq   [0:3][0:D];
    logic [14:0]   r_drnd [0:3][0:D];
    logic [15:0]   r_da   [0:3][0:D];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (ce) begin
            r_dv[0] <= r_lv;
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dm[0]   <= mx_all;
            r_dbig[0] <= 32'(mx_all) > ONE_VAL;
        end
    end

    for (genvar i = 0; i < D; i++) begin : g_dctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[i+1] <= 1'b0;
            end else if (ce) begin
                r_dv[i+1] <= r_dv[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_dm[i+1]   <= r_dm[i];
                r_dbig[i+1] <= r_dbig[i];
            end
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_div
        logic [LW:0] rnd_sum;
        assign rnd_sum = {1'b0, r_len[l]} + (LW+1)'(1 << (GUARD - 1));
        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_dr[l][0]   <= {1'b0, r_len[l]};
                r_dq[l][0]   <= '0;
                r_drnd[l][0] <= rnd_sum[GUARD+14:GUARD];
                r_da[l][0]   <= r_ang[l];
            end
        end
        // restoring division, one quotient bit per stage
        for (genvar i = 0; i < D; i++) begin : g_step
            logic          ge;
            logic [LW:0]   rn;
            assign ge = r_dr[l][i] >= {1'b0, r_dm[i]};
            assign rn = ge ? (r_dr[l][i] - {1'b0, r_dm[i]}) : r_dr[l][i];
            always_ff @(posedge i_clk) begin
                if (ce) begin
                    r_dr[l][i+1]   <= {rn[LW-1:0], 1'b0};
                    r_dq[l][i+1]   <= {r_dq[l][i][D-2:0], ge};
                    r_drnd[l][i+1] <= r_drnd[l][i];
                    r_da[l][i+1]   <= r_da[l][i];
                end
            end
        end
    end

    // ---------------- output register ----------------
    logic [14:0] sp [0:3];
    for (genvar l = 0; l < 4; l++) begin : g_sp
        assign sp[l] = r_dbig[D] ? 15'(r_dq[l][D]) : r_drnd[l][D];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ce) begin
            r_ov <= r_dv[D];
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_odata <= {4'h0, r_da[3][D], r_da[2][D], r_da[1][D], r_da[0][D],
                        sp[3], sp[2], sp[1], sp[0]};
        end
    end

    // ---------------- assertions ----------------
    // when normalizing, the divisor is one of the four lengths
    a_max_is_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[0] && r_dbig[0]) |->
            (r_dr[0][0][LW-1:0] == r_dm[0] || r_dr[1][0][LW-1:0] == r_dm[0] ||
             r_dr[2][0][LW-1:0] == r_dm[0] || r_dr[3][0][LW-1:0] == r_dm[0]))
        else $error("normalizing divisor is not a wheel length");

    // normalized speeds never exceed 1.0
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[D] && r_dbig[D]) |->
            (32'(r_dq[0][D]) <= (32'd1 << FRAC_BITS) &&
             32'(r_dq[1][D]) <= (32'd1 << FRAC_BITS) &&
             32'(r_dq[2][D]) <= (32'd1 << FRAC_BITS) &&
             32'(r_dq[3][D]) <= (32'd1 << FRAC_BITS)))
        else $error("normalized speed above 1.0");

    // a held result freezes the pipeline
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_m_axis_tready) |=> ($stable(r_kv) && $stable(r_lv) &&
                                        $stable(r_dv[0])))
        else $error("pipeline moved while output stalled");

endmodule
